/* sv/tpim_pkg.sv */
// ----------------------------------------------------------------------------
// tpim_pkg
// shared constants and the arctangent table of the two-photon mass pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpim_pkg;

    localparam int OUT_BITS   = 18;
    localparam int QUO_BITS   = 21;
    localparam int UNIT_SHIFT = 26;
    localparam int POS_FRAC   = 12;
    localparam int Z_W        = 33;
    localparam int CORDIC_W   = 45;
    localparam int NORM_EXP   = 40;
    localparam int ATAN_W     = 29;

    localparam logic signed [Z_W-1:0] PI_UNITS = 33'sd1073741824;

    function automatic logic [ATAN_W-1:0] f_atan(input int unsigned idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:  v = 29'd268435456;
            1:  v = 29'd158466703;
            2:  v = 29'd83729454;
            3:  v = 29'd42502378;
            4:  v = 29'd21333665;
            5:  v = 29'd10677233;
            6:  v = 29'd5339919;
            7:  v = 29'd2670123;
            8:  v = 29'd1335082;
            9:  v = 29'd667543;
            10: v = 29'd333772;
            11: v = 29'd166886;
            12: v = 29'd83443;
            13: v = 29'd41722;
            14: v = 29'd20861;
            15: v = 29'd10430;
            16: v = 29'd5215;
            17: v = 29'd2608;
            18: v = 29'd1304;
            19: v = 29'd652;
            20: v = 29'd326;
            21: v = 29'd163;
            22: v = 29'd81;
            23: v = 29'd41;
            24: v = 29'd20;
            25: v = 29'd10;
            26: v = 29'd5;
            27: v = 29'd3;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/tpim_delay.sv */
// ----------------------------------------------------------------------------
// tpim_delay
// side-band shift line with a reset valid bit, stalls with the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpim_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [DEPTH-1:0]            r_valid;
    logic [DEPTH-1:0][WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

`default_nettype wire

/* sv/tpim_sqrt.sv */
// ----------------------------------------------------------------------------
// tpim_sqrt
// integer square root, one result bit per cell, floor result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpim_sqrt #(
    parameter int IN_W  = 32,
    parameter int OUT_W = (IN_W + 1) / 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [IN_W-1:0]  i_val,
    output logic      [OUT_W-1:0] o_root
);

    localparam int VW = 2 * OUT_W;
    localparam int RW = OUT_W + 3;

    logic [RW-1:0]    w_rem  [0:OUT_W];
    logic [OUT_W-1:0] w_root [0:OUT_W];
    logic [VW-1:0]    w_val  [0:OUT_W];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_val[0]  = VW'(i_val);

    for (genvar g = 0; g < OUT_W; g++) begin : g_cell
        logic [RW-1:0]    w_cur;
        logic [RW-1:0]    w_trial;
        logic [RW-1:0]    r_rem;
        logic [OUT_W-1:0] r_root;
        logic [VW-1:0]    r_val;

        assign w_cur   = {w_rem[g][RW-3:0], w_val[g][VW-1:VW-2]};
        assign w_trial = RW'({w_root[g], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem  <= w_cur - w_trial;
                    r_root <= {w_root[g][OUT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_cur;
                    r_root <= {w_root[g][OUT_W-2:0], 1'b0};
                end
                r_val <= w_val[g] << 2;
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_val[g+1]  = r_val;
    end

    assign o_root = w_root[OUT_W];

endmodule

`default_nettype wire

/* sv/tpim_div.sv */
// ----------------------------------------------------------------------------
// tpim_div
// restoring divider, one quotient bit per cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpim_div #(
    parameter int N_W = 42,
    parameter int D_W = 23,
    parameter int Q_W = 21
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic      [Q_W-1:0] o_quo
);

    localparam int RW = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

    logic [RW-1:0]  w_rem [0:Q_W];
    logic [D_W-1:0] w_den [0:Q_W];
    logic [Q_W-1:0] w_quo [0:Q_W];

    assign w_rem[0] = RW'(i_num);
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        logic [RW-1:0]  w_sub;
        logic [RW-1:0]  r_rem;
        logic [D_W-1:0] r_den;
        logic [Q_W-1:0] r_quo;

        assign w_sub = RW'(w_den[g]) << (Q_W - 1 - g);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem[g] >= w_sub) begin
                    r_rem <= w_rem[g] - w_sub;
                    r_quo <= {w_quo[g][Q_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem[g];
                    r_quo <= {w_quo[g][Q_W-2:0], 1'b0};
                end
                r_den <= w_den[g];
            end
        end

        assign w_rem[g+1] = r_rem;
        assign w_den[g+1] = r_den;
        assign w_quo[g+1] = r_quo;
    end

    assign o_quo = w_quo[Q_W];

endmodule

`default_nettype wire

/* sv/tpim_cordic.sv */
// ----------------------------------------------------------------------------
// tpim_cordic
// vectoring cordic atan2 with half-turn fold and operand normalization
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpim_cordic #(
    parameter int IN_W  = 24,
    parameter int ITERS = 18
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [IN_W-1:0]            i_y,
    input  wire logic signed [IN_W-1:0]            i_x,
    output logic signed      [tpim_pkg::Z_W-1:0]   o_z
);

    import tpim_pkg::*;

    logic signed [IN_W:0]     r_a_x;
    logic signed [IN_W:0]     r_a_y;
    logic signed [Z_W-1:0]    r_a_z;
    logic                     r_a_zero;

    logic signed [CORDIC_W-1:0] n_b_x;
    logic signed [CORDIC_W-1:0] n_b_y;
    logic signed [CORDIC_W-1:0] r_b_x;
    logic signed [CORDIC_W-1:0] r_b_y;
    logic signed [Z_W-1:0]      r_b_z;
    logic                       r_b_zero;

    logic signed [CORDIC_W-1:0] w_x    [0:ITERS];
    logic signed [CORDIC_W-1:0] w_y    [0:ITERS];
    logic signed [Z_W-1:0]      w_z    [0:ITERS];
    logic                       w_zero [0:ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_a_z <= (i_y >= 0) ? PI_UNITS : -PI_UNITS;
                r_a_x <= -(IN_W+1)'(i_x);
                r_a_y <= -(IN_W+1)'(i_y);
            end else begin
                r_a_z <= '0;
                r_a_x <= (IN_W+1)'(i_x);
                r_a_y <= (IN_W+1)'(i_y);
            end
        end
    end

    always_comb begin
        logic [CORDIC_W-1:0]        m;
        logic signed [CORDIC_W-1:0] ay;
        n_b_x = CORDIC_W'(r_a_x);
        n_b_y = CORDIC_W'(r_a_y);
        ay    = (n_b_y < 0) ? -n_b_y : n_b_y;
        m     = (n_b_x > ay) ? n_b_x : ay;
        for (int k = 5; k >= 0; k--) begin
            if (m < (CORDIC_W'(1) << (NORM_EXP - (1 << k)))) begin
                m     = m << (1 << k);
                n_b_x = n_b_x <<< (1 << k);
                n_b_y = n_b_y <<< (1 << k);
            end
        end
        n_b_x = n_b_x <<< 1;
        n_b_y = n_b_y <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_z    <= r_a_z;
            r_b_zero <= r_a_zero;
        end
    end

    assign w_x[0]    = r_b_x;
    assign w_y[0]    = r_b_y;
    assign w_z[0]    = r_b_z;
    assign w_zero[0] = r_b_zero;

    for (genvar g = 0; g < ITERS; g++) begin : g_cell
        logic signed [Z_W-1:0]      w_ang;
        logic signed [CORDIC_W-1:0] r_x;
        logic signed [CORDIC_W-1:0] r_y;
        logic signed [Z_W-1:0]      r_z;
        logic                       r_zero;

        assign w_ang = $signed({{(Z_W-ATAN_W){1'b0}}, f_atan(g)});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y[g] >= 0) begin
                    r_x <= w_x[g] + (w_y[g] >>> g);
                    r_y <= w_y[g] - (w_x[g] >>> g);
                    r_z <= w_z[g] + w_ang;
                end else begin
                    r_x <= w_x[g] - (w_y[g] >>> g);
                    r_y <= w_y[g] + (w_x[g] >>> g);
                    r_z <= w_z[g] - w_ang;
                end
                r_zero <= w_zero[g];
            end
        end

        assign w_x[g+1]    = r_x;
        assign w_y[g+1]    = r_y;
        assign w_z[g+1]    = r_z;
        assign w_zero[g+1] = r_zero;
    end

    assign o_z = w_zero[ITERS] ? '0 : w_z[ITERS];

endmodule

`default_nettype wire

/* sv/two_photon_invariant_mass_unit.sv */
// ----------------------------------------------------------------------------
// two_photon_invariant_mass_unit
// pair energy, transverse momentum, invariant mass and angles of two clusters
// ----------------------------------------------------------------------------
// Fully pipelined: one cluster pair is accepted per clock while the output is
// not held, and every pair gives one result. Its path runs through the cells of
// the position-length square root, the 21-bit unit-vector divider, the momentum
// square root and the arctangent cordic, besides the registered stages around
// them. The whole pipeline holds while a result waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module two_photon_invariant_mass_unit #(
    parameter int ENERGY_BITS   = 17,
    parameter int POSITION_BITS = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // first_energy, first_x, first_y, first_z, second_energy, second_x,
    // second_y, second_z, vertex_z
    input  wire logic [((2*ENERGY_BITS+7*POSITION_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // first_arm, second_arm, same_event
    input  wire logic [2:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // pair_energy, pair_pt, pair_mass, pair_theta, pair_phi
    output logic [((3*tpim_pkg::OUT_BITS+2*ANGLE_BITS+1+7)/8)*8-1:0] o_m_axis_tdata,
    // status, pair_arm
    output logic [2:0] o_m_axis_tuser
);

    import tpim_pkg::*;

    localparam int EB   = ENERGY_BITS;
    localparam int PB   = POSITION_BITS;
    localparam int AB   = ANGLE_BITS;
    localparam int L2W  = 2 * PB + 1;
    localparam int SQ1W = L2W + POS_FRAC;
    localparam int LQW  = (SQ1W + 1) / 2;
    localparam int NUMW = PB + UNIT_SHIFT;
    localparam int PW   = EB + 6;
    localparam int SQW  = 2 * EB + 10;
    localparam int MW   = SQW + 2;
    localparam int SQ2W = SQW + 1;
    localparam int RTW  = (SQ2W + 1) / 2;
    localparam int CIW  = EB + 7;
    localparam int AW   = AB + 3;
    localparam int ODW  = 3 * OUT_BITS + 2 * AB + 1;
    localparam int ODP  = ((ODW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISMATCH,
        ST_NEG_MASS,
        ST_ZERO_LEN
    } t_status;

    typedef struct packed {
        logic          arm;
        logic          mism;
        logic          zero;
        logic [EB-1:0] e1;
        logic [EB-1:0] e2;
        logic [5:0]    neg;
    } t_dside;

    typedef struct packed {
        t_dside             d;
        logic [5:0][PB-1:0] mag;
    } t_s1;

    typedef struct packed {
        t_status              status;
        logic                 arm;
        logic [EB:0]          esum;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
    } t_s6;

    typedef struct packed {
        t_status        status;
        logic           arm;
        logic [EB:0]    esum;
        logic [RTW-1:0] ptq;
        logic [RTW-1:0] mroot;
    } t_s7;

    logic w_en;

    // input unpack
    logic [EB-1:0]        w_e1;
    logic [EB-1:0]        w_e2;
    logic signed [PB:0]   w_c   [6];
    logic [PB-1:0]        w_mag [6];
    logic signed [PB:0]   w_vz;

    // stage 1
    logic                 r1_vld;
    logic [2*PB-1:0]      r1_sq  [6];
    logic [PB-1:0]        r1_mag [6];
    logic [5:0]           r1_neg;
    logic [EB-1:0]        r1_e1;
    logic [EB-1:0]        r1_e2;
    logic                 r1_arm1;
    logic                 r1_arm2;
    logic                 r1_same;

    // stage 2
    logic                 r2_vld;
    logic [L2W-1:0]       r2_l2a;
    logic [L2W-1:0]       r2_l2b;
    t_s1                  r2_side;
    logic [L2W-1:0]       w_l2a;
    logic [L2W-1:0]       w_l2b;

    // length square root
    logic [LQW-1:0]       w_lqa;
    logic [LQW-1:0]       w_lqb;
    logic                 w_s1_vld;
    t_s1                  w_s1;

    // unit vector division
    logic [QUO_BITS-1:0]  w_u [6];
    logic                 w_d_vld;
    t_dside               w_d;

    // stage 3
    logic                 r3_vld;
    logic signed [PW-1:0] r3_p [6];
    t_dside               r3_side;

    // stage 4
    logic                 r4_vld;
    logic signed [PW-1:0] r4_px;
    logic signed [PW-1:0] r4_py;
    logic signed [PW-1:0] r4_pz;
    logic [EB:0]          r4_esum;
    logic                 r4_arm;
    logic                 r4_mism;
    logic                 r4_zero;

    // stage 5
    logic                 r5_vld;
    logic [SQW-1:0]       r5_pxx;
    logic [SQW-1:0]       r5_pyy;
    logic [SQW-1:0]       r5_pzz;
    logic [SQW-1:0]       r5_ess;
    logic signed [PW-1:0] r5_px;
    logic signed [PW-1:0] r5_py;
    logic signed [PW-1:0] r5_pz;
    logic [EB:0]          r5_esum;
    logic                 r5_arm;
    logic                 r5_mism;
    logic                 r5_zero;
    logic signed [2*PW-1:0] w_pxx;
    logic signed [2*PW-1:0] w_pyy;
    logic signed [2*PW-1:0] w_pzz;
    logic [EB+4:0]        w_es;

    // stage 6
    logic                 r6_vld;
    logic [SQ2W-1:0]      r6_pt2;
    logic [SQ2W-1:0]      r6_m2;
    t_s6                  r6_side;
    logic signed [MW-1:0] w_m2;
    t_status              w_status;

    // momentum square roots
    logic [RTW-1:0]       w_ptq;
    logic [RTW-1:0]       w_mroot;
    logic                 w_s6_vld;
    t_s6                  w_s6;
    t_s7                  w_s7_in;

    // angles
    logic signed [Z_W-1:0] w_zt;
    logic signed [Z_W-1:0] w_zp;
    logic                  w_s7_vld;
    t_s7                   w_s7;
    logic signed [Z_W:0]   w_tsum;
    logic signed [Z_W:0]   w_psum;
    logic signed [AW-1:0]  w_theta;
    logic signed [AW-1:0]  w_phi;
    logic [AB-1:0]         n_theta;
    logic signed [AB:0]    n_phi;
    logic [OUT_BITS-1:0]   n_energy;
    logic [OUT_BITS-1:0]   n_pt;
    logic [OUT_BITS-1:0]   n_mass;

    // output register
    logic                  r_out_vld;
    t_status               r_out_status;
    logic                  r_out_arm;
    logic [OUT_BITS-1:0]   r_out_energy;
    logic [OUT_BITS-1:0]   r_out_pt;
    logic [OUT_BITS-1:0]   r_out_mass;
    logic [AB-1:0]         r_out_theta;
    logic signed [AB:0]    r_out_phi;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- input, per-component magnitudes and squares
    assign w_e1 = i_s_axis_tdata[0 +: EB];
    assign w_e2 = i_s_axis_tdata[EB+3*PB +: EB];
    assign w_vz = (PB+1)'($signed(i_s_axis_tdata[2*EB+6*PB +: PB]));

    always_comb begin
        w_c[0] = (PB+1)'($signed(i_s_axis_tdata[EB +: PB]));
        w_c[1] = (PB+1)'($signed(i_s_axis_tdata[EB+PB +: PB]));
        w_c[2] = (PB+1)'($signed(i_s_axis_tdata[EB+2*PB +: PB])) - w_vz;
        w_c[3] = (PB+1)'($signed(i_s_axis_tdata[2*EB+3*PB +: PB]));
        w_c[4] = (PB+1)'($signed(i_s_axis_tdata[2*EB+4*PB +: PB]));
        w_c[5] = (PB+1)'($signed(i_s_axis_tdata[2*EB+5*PB +: PB])) - w_vz;
        for (int i = 0; i < 6; i++) begin
            w_mag[i] = (w_c[i] < 0) ? PB'(-w_c[i]) : PB'(w_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r1_sq[i]  <= (2*PB)'(w_mag[i]) * (2*PB)'(w_mag[i]);
                r1_mag[i] <= w_mag[i];
                r1_neg[i] <= w_c[i] < 0;
            end
            r1_e1   <= w_e1;
            r1_e2   <= w_e2;
            r1_arm1 <= i_s_axis_tuser[0];
            r1_arm2 <= i_s_axis_tuser[1];
            r1_same <= i_s_axis_tuser[2];
        end
    end

    // ---------------- squared lengths and pair flags
    assign w_l2a = L2W'(r1_sq[0]) + L2W'(r1_sq[1]) + L2W'(r1_sq[2]);
    assign w_l2b = L2W'(r1_sq[3]) + L2W'(r1_sq[4]) + L2W'(r1_sq[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_l2a         <= w_l2a;
            r2_l2b         <= w_l2b;
            r2_side.d.arm  <= r1_arm1;
            r2_side.d.mism <= (r1_arm1 != r1_arm2) || !r1_same;
            r2_side.d.zero <= (w_l2a == '0) || (w_l2b == '0);
            r2_side.d.e1   <= r1_e1;
            r2_side.d.e2   <= r1_e2;
            r2_side.d.neg  <= r1_neg;
            for (int i = 0; i < 6; i++) begin
                r2_side.mag[i] <= r1_mag[i];
            end
        end
    end

    tpim_sqrt #(.IN_W(SQ1W), .OUT_W(LQW)) u_sqrt_len_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r2_l2a, {POS_FRAC{1'b0}}}),
        .o_root (w_lqa)
    );

    tpim_sqrt #(.IN_W(SQ1W), .OUT_W(LQW)) u_sqrt_len_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r2_l2b, {POS_FRAC{1'b0}}}),
        .o_root (w_lqb)
    );

    tpim_delay #(.WIDTH($bits(t_s1)), .DEPTH(LQW)) u_dly_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_data  (r2_side),
        .o_valid (w_s1_vld),
        .o_data  (w_s1)
    );

    // ---------------- unit vector components
    for (genvar gi = 0; gi < 6; gi++) begin : g_unit
        tpim_div #(.N_W(NUMW), .D_W(LQW), .Q_W(QUO_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num ({w_s1.mag[gi], {UNIT_SHIFT{1'b0}}}),
            .i_den ((gi < 3) ? w_lqa : w_lqb),
            .o_quo (w_u[gi])
        );
    end

    tpim_delay #(.WIDTH($bits(t_dside)), .DEPTH(QUO_BITS)) u_dly_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s1_vld),
        .i_data  (w_s1.d),
        .o_valid (w_d_vld),
        .o_data  (w_d)
    );

    // ---------------- photon momentum components
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [EB+QUO_BITS-1:0] prod;
        logic [EB+4:0]          q;
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                prod = (EB+QUO_BITS)'((i < 3) ? w_d.e1 : w_d.e2)
                     * (EB+QUO_BITS)'(w_u[i])
                     + (EB+QUO_BITS)'(1 << 15);
                q = prod[EB+QUO_BITS-1:16];
                r3_p[i] <= w_d.neg[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            end
            r3_side <= w_d;
        end
    end

    // ---------------- pair sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_px   <= r3_p[0] + r3_p[3];
            r4_py   <= r3_p[1] + r3_p[4];
            r4_pz   <= r3_p[2] + r3_p[5];
            r4_esum <= (EB+1)'(r3_side.e1) + (EB+1)'(r3_side.e2);
            r4_arm  <= r3_side.arm;
            r4_mism <= r3_side.mism;
            r4_zero <= r3_side.zero;
        end
    end

    // ---------------- squares
    assign w_pxx = r4_px * r4_px;
    assign w_pyy = r4_py * r4_py;
    assign w_pzz = r4_pz * r4_pz;
    assign w_es  = {r4_esum, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_pxx  <= w_pxx[SQW-1:0];
            r5_pyy  <= w_pyy[SQW-1:0];
            r5_pzz  <= w_pzz[SQW-1:0];
            r5_ess  <= SQW'(w_es) * SQW'(w_es);
            r5_px   <= r4_px;
            r5_py   <= r4_py;
            r5_pz   <= r4_pz;
            r5_esum <= r4_esum;
            r5_arm  <= r4_arm;
            r5_mism <= r4_mism;
            r5_zero <= r4_zero;
        end
    end

    // ---------------- mass squared and status
    assign w_m2 = $signed({2'b00, r5_ess}) - $signed({2'b00, r5_pxx})
                - $signed({2'b00, r5_pyy}) - $signed({2'b00, r5_pzz});

    always_comb begin
        if (r5_zero) begin
            w_status = ST_ZERO_LEN;
        end else if (r5_mism) begin
            w_status = ST_MISMATCH;
        end else if (w_m2 < 0) begin
            w_status = ST_NEG_MASS;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_pt2         <= SQ2W'(r5_pxx) + SQ2W'(r5_pyy);
            r6_m2          <= (w_m2 < 0) ? '0 : w_m2[SQ2W-1:0];
            r6_side.status <= w_status;
            r6_side.arm    <= r5_arm;
            r6_side.esum   <= r5_esum;
            r6_side.px     <= r5_px;
            r6_side.py     <= r5_py;
            r6_side.pz     <= r5_pz;
        end
    end

    tpim_sqrt #(.IN_W(SQ2W), .OUT_W(RTW)) u_sqrt_pt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r6_pt2),
        .o_root (w_ptq)
    );

    tpim_sqrt #(.IN_W(SQ2W), .OUT_W(RTW)) u_sqrt_mass (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r6_m2),
        .o_root (w_mroot)
    );

    tpim_delay #(.WIDTH($bits(t_s6)), .DEPTH(RTW)) u_dly_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_data  (r6_side),
        .o_valid (w_s6_vld),
        .o_data  (w_s6)
    );

    // ---------------- polar angle and azimuth
    tpim_cordic #(.IN_W(CIW), .ITERS(CORDIC_STAGES)) u_cordic_theta (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   ($signed(CIW'(w_ptq))),
        .i_x   (CIW'(w_s6.pz)),
        .o_z   (w_zt)
    );

    tpim_cordic #(.IN_W(CIW), .ITERS(CORDIC_STAGES)) u_cordic_phi (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (CIW'(w_s6.py)),
        .i_x   (CIW'(w_s6.px)),
        .o_z   (w_zp)
    );

    assign w_s7_in.status = w_s6.status;
    assign w_s7_in.arm    = w_s6.arm;
    assign w_s7_in.esum   = w_s6.esum;
    assign w_s7_in.ptq    = w_ptq;
    assign w_s7_in.mroot  = w_mroot;

    tpim_delay #(.WIDTH($bits(t_s7)), .DEPTH(CORDIC_STAGES + 2)) u_dly_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s6_vld),
        .i_data  (w_s7_in),
        .o_valid (w_s7_vld),
        .o_data  (w_s7)
    );

    // ---------------- rounding, clamping, saturation
    assign w_tsum  = (Z_W+1)'(w_zt) + ((Z_W+1)'(1) <<< (30 - AB));
    assign w_psum  = (Z_W+1)'(w_zp) + ((Z_W+1)'(1) <<< (30 - AB));
    assign w_theta = AW'(w_tsum >>> (31 - AB));
    assign w_phi   = AW'(w_psum >>> (31 - AB));

    always_comb begin
        if (w_theta < 0) begin
            n_theta = '0;
        end else if (w_theta > (AW'(1) <<< (AB - 1))) begin
            n_theta = AB'(1) << (AB - 1);
        end else begin
            n_theta = AB'(w_theta);
        end
        if (w_phi < -(AW'(1) <<< (AB - 2))) begin
            n_phi = (AB+1)'(w_phi + (AW'(1) <<< AB));
        end else begin
            n_phi = (AB+1)'(w_phi);
        end
        n_energy = (64'(w_s7.esum) > 64'((1 << OUT_BITS) - 1)) ? '1 : OUT_BITS'(w_s7.esum);
        n_pt     = (64'(w_s7.ptq >> 4) > 64'((1 << OUT_BITS) - 1)) ? '1
                 : OUT_BITS'(w_s7.ptq >> 4);
        n_mass   = (64'(w_s7.mroot >> 4) > 64'((1 << OUT_BITS) - 1)) ? '1
                 : OUT_BITS'(w_s7.mroot >> 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= w_s7.status;
            if (w_s7.status == ST_OK) begin
                r_out_arm    <= w_s7.arm;
                r_out_energy <= n_energy;
                r_out_pt     <= n_pt;
                r_out_mass   <= n_mass;
                r_out_theta  <= n_theta;
                r_out_phi    <= n_phi;
            end else begin
                r_out_arm    <= 1'b0;
                r_out_energy <= '0;
                r_out_pt     <= '0;
                r_out_mass   <= '0;
                r_out_theta  <= '0;
                r_out_phi    <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(ODP-ODW){1'b0}}, r_out_phi, r_out_theta,
                              r_out_mass, r_out_pt, r_out_energy};
    assign o_m_axis_tuser  = {r_out_arm, r_out_status};

endmodule

`default_nettype wire

/* test/two_photon_invariant_mass_checker.sv */
// ----------------------------------------------------------------------------
// two_photon_invariant_mass_checker
// watches both stream channels of the two-photon mass unit, predicts each
// pair result from the accepted cluster pair and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_photon_invariant_mass_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    input  wire logic [151:0] i_s_axis_tdata,
    input  wire logic [2:0]   i_s_axis_tuser,
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [87:0]  i_m_axis_tdata,
    input  wire logic [2:0]   i_m_axis_tuser,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int ANGLE_W   = 16;
    localparam int STAGES    = 18;
    localparam longint PI_Q  = 64'sd1073741824;
    localparam longint OUT_MAX = 64'd262143;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_NEG_M2   = 2'd2;
    localparam logic [1:0] ST_ZERO_LEN = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic               arm;
        logic [17:0]        energy;
        logic [17:0]        pt;
        logic [17:0]        mass;
        logic [15:0]        theta;
        logic signed [16:0] phi;
    } pair_result_t;

    longint arctan_q [28] = '{
        268435456, 158466703, 83729454, 42502378, 21333665, 10677233, 5339919,
        2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3
    };

    pair_result_t expected_pairs [$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_pairs.size();

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit photon_momentum(input longint e, input longint cx,
                                           input longint cy, input longint cz,
                                           output longint mx, output longint my,
                                           output longint mz);
        longint c [3];
        longint m [3];
        longint unsigned len2, lenq, mag, unit, q;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        len2 = cx * cx + cy * cy + cz * cz;
        mx = 0;
        my = 0;
        mz = 0;
        if (len2 == 0) return 0;
        lenq = int_sqrt(len2 << 12);
        for (int i = 0; i < 3; i++) begin
            mag  = (c[i] < 0) ? -c[i] : c[i];
            unit = (mag << 26) / lenq;
            q    = (e * unit + (64'd1 << 15)) >> 16;
            m[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        mx = m[0];
        my = m[1];
        mz = m[2];
        return 1;
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, xs, ys, ay;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        forever begin
            ay = (y < 0) ? -y : y;
            if (x >= (64'sd1 << 40) || ay >= (64'sd1 << 40)) break;
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q[i];
            end
        end
        return (z + (64'sd1 << (30 - ANGLE_W))) >>> (31 - ANGLE_W);
    endfunction

    function automatic pair_result_t predict_pair(input logic [151:0] d,
                                                  input logic [2:0] u);
        pair_result_t r;
        longint e1, e2, vz, ax, ay, az, bx, by, bz, px, py, pz, es, m2, th, ph;
        longint unsigned ptq;
        bit ok1, ok2;
        r  = '0;
        e1 = d[16:0];
        e2 = d[81:65];
        vz = longint'($signed(d[145:130]));
        ok1 = photon_momentum(e1, longint'($signed(d[32:17])), longint'($signed(d[48:33])),
                              longint'($signed(d[64:49])) - vz, ax, ay, az);
        ok2 = photon_momentum(e2, longint'($signed(d[97:82])), longint'($signed(d[113:98])),
                              longint'($signed(d[129:114])) - vz, bx, by, bz);
        if (!ok1 || !ok2) begin
            r.status = ST_ZERO_LEN;
            return r;
        end
        if (u[0] != u[1] || !u[2]) begin
            r.status = ST_MISMATCH;
            return r;
        end
        px = ax + bx;
        py = ay + by;
        pz = az + bz;
        es = (e1 + e2) * 16;
        m2 = es * es - px * px - py * py - pz * pz;
        if (m2 < 0) begin
            r.status = ST_NEG_M2;
            return r;
        end
        ptq = int_sqrt(px * px + py * py);
        th  = vector_angle(longint'(ptq), pz);
        if (th < 0) th = 0;
        if (th > (64'sd1 << (ANGLE_W - 1))) th = 64'sd1 << (ANGLE_W - 1);
        ph = vector_angle(py, px);
        if (ph < -(64'sd1 << (ANGLE_W - 2))) ph = ph + (64'sd1 << ANGLE_W);
        r.status = ST_OK;
        r.arm    = u[0];
        r.energy = ((e1 + e2) > OUT_MAX) ? OUT_MAX : (e1 + e2);
        r.pt     = ((ptq >> 4) > OUT_MAX) ? OUT_MAX : (ptq >> 4);
        r.mass   = ((int_sqrt(m2) >> 4) > OUT_MAX) ? OUT_MAX : (int_sqrt(m2) >> 4);
        r.theta  = th[15:0];
        r.phi    = ph[16:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        pair_result_t want, got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_pairs.push_back(predict_pair(i_s_axis_tdata, i_s_axis_tuser));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status = i_m_axis_tuser[1:0];
                got.arm    = i_m_axis_tuser[2];
                got.energy = i_m_axis_tdata[17:0];
                got.pt     = i_m_axis_tdata[35:18];
                got.mass   = i_m_axis_tdata[53:36];
                got.theta  = i_m_axis_tdata[69:54];
                got.phi    = i_m_axis_tdata[86:70];
                if (expected_pairs.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected transaction, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_pairs.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("pair_arm", want.arm, got.arm);
                    compare_field("pair_energy", want.energy, got.energy);
                    compare_field("pair_pt", want.pt, got.pt);
                    compare_field("pair_mass", want.mass, got.mass);
                    compare_field("pair_theta", want.theta, got.theta);
                    compare_field("pair_phi", want.phi, got.phi);
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random cluster pairs into the two-photon mass unit
// under varying source and sink idling and reports the checker verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 94;
    localparam int LIMIT   = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // first_energy, first_x, first_y, first_z, second_energy, second_x,
    // second_y, second_z, vertex_z
    logic [151:0] s_tdata;
    // first_arm, second_arm, same_event
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // pair_energy, pair_pt, pair_mass, pair_theta, pair_phi
    logic [87:0]  m_tdata;
    // status, pair_arm
    logic [2:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           cycles;

    two_photon_invariant_mass_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    two_photon_invariant_mass_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_pair(input logic [16:0] e1, input logic [15:0] x1,
                             input logic [15:0] y1, input logic [15:0] z1,
                             input logic [16:0] e2, input logic [15:0] x2,
                             input logic [15:0] y2, input logic [15:0] z2,
                             input logic [15:0] vz, input logic a1,
                             input logic a2, input logic se);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, vz, z2, y2, x2, e2, z1, y1, x1, e1};
        s_tuser  <= {se, a2, a1};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic send_random_pair();
        logic [16:0] e1, e2;
        logic [15:0] x1, y1, z1, x2, y2, z2, vz;
        logic        a;
        if ($urandom_range(99) < 85) begin
            e1 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000);
            e2 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000);
            x1 = $urandom_range(60000) - 30000;
            y1 = $urandom_range(60000) - 30000;
            x2 = $urandom_range(60000) - 30000;
            y2 = $urandom_range(60000) - 30000;
            a  = $urandom;
            z1 = a ? $urandom_range(32767, 20000) : -$urandom_range(32768, 20000);
            z2 = ($urandom_range(3) == 0) ? z1 + $urandom_range(200) - 100 :
                 (a ? $urandom_range(32767, 20000) : -$urandom_range(32768, 20000));
            vz = $urandom_range(6000) - 3000;
            if ($urandom_range(9) == 0) begin
                x2 = x1;
                y2 = y1;
                z2 = z1;
            end
            send_pair(e1, x1, y1, z1, e2, x2, y2, z2, vz, a, a, 1'b1);
        end else begin
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        tx_idle_pct = 21;
        rx_idle_pct = 47;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of energy and position
        send_pair(17'h1ffff, 16'h7fff, 16'h0, 16'h0, 17'h1ffff, 16'h8000, 16'h0, 16'h0,
                  16'h0, 1'b1, 1'b1, 1'b1);
        send_pair(17'h1ffff, 16'h8000, 16'h8000, 16'h8000, 17'h1ffff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b1);
        send_pair(17'h1ffff, 16'h8000, 16'h8000, 16'h8000, 17'h0, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1);
        // zero energies give zero vectors in both angles
        send_pair(17'h0, 16'd100, 16'd200, 16'd3000, 17'h0, 16'd50, 16'd60, 16'd70,
                  16'd0, 1'b0, 1'b0, 1'b1);
        // zero position length, also over a mismatch
        send_pair(17'd1000, 16'd0, 16'd0, 16'd500, 17'd900, 16'd10, 16'd20, 16'd30,
                  16'd500, 1'b0, 1'b0, 1'b1);
        send_pair(17'd1000, 16'd10, 16'd0, 16'd500, 17'd900, 16'd0, 16'd0, 16'hff00,
                  16'hff00, 1'b0, 1'b1, 1'b0);
        // arm mismatch and event mismatch
        send_pair(17'd5000, 16'd1000, 16'd2000, 16'd30000, 17'd4000, 16'hfc00, 16'd500,
                  16'd30000, 16'd0, 1'b1, 1'b0, 1'b1);
        send_pair(17'd5000, 16'd1000, 16'd2000, 16'd30000, 17'd4000, 16'hfc00, 16'd500,
                  16'd30000, 16'd0, 1'b1, 1'b1, 1'b0);
        // collinear photons, mass squared near zero from either side
        send_pair(17'd5000, 16'd1000, 16'd2000, 16'd30000, 17'd5000, 16'd1000,
                  16'd2000, 16'd30000, 16'd0, 1'b1, 1'b1, 1'b1);
        send_pair(17'd131071, 16'd3, 16'd7, 16'd11, 17'd131071, 16'd3, 16'd7, 16'd11,
                  16'd0, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++) begin
            logic [15:0] cx, cy, cz;
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
            send_pair($urandom, cx, cy, cz, $urandom, cx, cy, cz, 16'd0, 1'b1, 1'b1, 1'b1);
        end
        // phi near pi on both sides of the wrap, theta near pi
        send_pair(17'd3000, 16'hd000, 16'd0, 16'd100, 17'd3000, 16'hd000, 16'd1, 16'd100,
                  16'd100, 1'b0, 1'b0, 1'b1);
        send_pair(17'd3000, 16'hd000, 16'hffff, 16'd100, 17'd3000, 16'hd000, 16'hfffe,
                  16'd100, 16'd100, 1'b0, 1'b0, 1'b1);
        send_pair(17'd3000, 16'd10, 16'hfff0, 16'h8000, 17'd2000, 16'hfff6, 16'd20,
                  16'h8000, 16'd0, 1'b1, 1'b1, 1'b1);
        send_pair(17'd3000, 16'd0, 16'hd000, 16'd0, 17'd3000, 16'd2, 16'hd000, 16'd0,
                  16'd0, 1'b1, 1'b1, 1'b1);
        drain();

        for (int i = 0; i < 550; i++) send_random_pair();
        drain();
        tx_idle_pct = 47;
        rx_idle_pct = 21;
        for (int i = 0; i < 550; i++) send_random_pair();
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 500; i++) send_random_pair();
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* two_photon_invariant_mass_unit.f */
sv/tpim_pkg.sv
sv/tpim_delay.sv
sv/tpim_sqrt.sv
sv/tpim_div.sv
sv/tpim_cordic.sv
sv/two_photon_invariant_mass_unit.sv
test/two_photon_invariant_mass_checker.sv
test/tb_top.sv
